@@ rtl/core/vfmu_pkg.sv @@
package vfmu_pkg;

  localparam int unsigned NUM_FACES = 6;

  typedef logic [4:0] coord_t;
  typedef logic [5:0] dim_t;
  typedef logic [5:0] mask_t;
  typedef logic [2:0] kind_t;
  typedef logic [2:0] face_t;
  typedef logic [1:0] reg_idx_t;

  // Result kinds.
  localparam kind_t EV_UNCHANGED = 3'd0;
  localparam kind_t EV_CLEARED   = 3'd1;
  localparam kind_t EV_CHANGED   = 3'd2;
  localparam kind_t EV_INSERTED  = 3'd3;
  localparam kind_t EV_REJECTED  = 3'd4;
  localparam kind_t EV_SHOWN     = 3'd5;
  localparam kind_t EV_HIDDEN    = 3'd6;

  // Face numbers; mask bit f belongs to face f.
  localparam face_t FACE_PZ = 3'd0;
  localparam face_t FACE_PX = 3'd1;
  localparam face_t FACE_NZ = 3'd2;
  localparam face_t FACE_NX = 3'd3;
  localparam face_t FACE_PY = 3'd4;
  localparam face_t FACE_NY = 3'd5;

  // Configuration register indexes.
  localparam reg_idx_t REG_GRID_WIDTH  = 2'd0;
  localparam reg_idx_t REG_GRID_DEPTH  = 2'd1;
  localparam reg_idx_t REG_GRID_HEIGHT = 2'd2;

  localparam dim_t  DIM_RESET = 6'd32;
  localparam mask_t ALL_FACES = 6'b111111;

  typedef struct packed {
    logic [7:0] mat;
    mask_t      mask;
  } cell_t;

  localparam cell_t EMPTY_CELL = '{mat: 8'hFF, mask: 6'h00};

  // Face on the far side of a shared boundary.
  function automatic face_t across(face_t f);
    face_t r;
    case (f)
      FACE_PZ: r = FACE_NZ;
      FACE_PX: r = FACE_NX;
      FACE_NZ: r = FACE_PZ;
      FACE_NX: r = FACE_PX;
      FACE_PY: r = FACE_NY;
      FACE_NY: r = FACE_PY;
      default: r = FACE_PZ;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/vfmu_if.sv @@
interface vfmu_in_if;
  logic                  valid;
  logic                  ready;
  vfmu_pkg::coord_t      x_pos;
  vfmu_pkg::coord_t      y_pos;
  vfmu_pkg::coord_t      z_pos;
  logic signed [7:0]     material;

  modport source (output valid, x_pos, y_pos, z_pos, material, input ready);
  modport sink   (input valid, x_pos, y_pos, z_pos, material, output ready);
endinterface

interface vfmu_out_if;
  logic                  valid;
  logic                  ready;
  vfmu_pkg::kind_t       event_kind;
  vfmu_pkg::coord_t      cell_x;
  vfmu_pkg::coord_t      cell_y;
  vfmu_pkg::coord_t      cell_z;
  vfmu_pkg::face_t       face;
  vfmu_pkg::mask_t       cell_mask;
  logic                  last;

  modport source (output valid, event_kind, cell_x, cell_y, cell_z, face, cell_mask, last,
                  input ready);
  modport sink   (input valid, event_kind, cell_x, cell_y, cell_z, face, cell_mask, last,
                  output ready);
endinterface

interface vfmu_cfg_if;
  logic                  valid;
  logic                  ready;
  vfmu_pkg::reg_idx_t    index;
  vfmu_pkg::dim_t        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/vfmu_ram.sv @@
module vfmu_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/voxel_face_mask_updater.sv @@
// Voxel face mask updater.
//
// in_chan carries one voxel update per transaction: a coordinate and a signed
// material, a negative material meaning remove. out_chan returns one status
// transaction per update followed by up to six face shown or face hidden
// transactions; the final one of each update has last set. cfg_chan writes the
// grid size registers (width, depth, height) and is always ready; the user must
// ensure it is written only while the block is idle; the block does not check.
//
// All state lives in one single-port voxel memory with a registered read. An
// update that only touches the target cell (rejected, unchanged, material
// changed) reads that cell and rewrites it if changed. A removal reads the
// six neighbours and rewrites the occupied ones; an insertion also walks its
// own six faces. The single memory port serves one read or one write per
// cycle. in_chan is ready only between updates.
//
// Results leave through an output register, so the sequencer carries on while
// a finished result waits; when the receiver stalls the sequencer holds at its
// next emitting step. After reset the block sweeps the memory (2**(clog2 of
// each grid bound capped at 32, summed) cells, 32768 with the default bounds)
// to empty, one cell a cycle, and takes no update before the sweep ends.
module voxel_face_mask_updater #(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned MAX_DEPTH  = 32,
  parameter int unsigned MAX_HEIGHT = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  vfmu_in_if.sink       in_chan,
  vfmu_out_if.source    out_chan,
  vfmu_cfg_if.sink      cfg_chan
);

  // Coordinates are five bits wide, so at most 32 cells per axis are reachable.
  localparam int unsigned X_LIM = (MAX_WIDTH  > 32) ? 32 : MAX_WIDTH;
  localparam int unsigned Y_LIM = (MAX_HEIGHT > 32) ? 32 : MAX_HEIGHT;
  localparam int unsigned Z_LIM = (MAX_DEPTH  > 32) ? 32 : MAX_DEPTH;
  localparam int unsigned XW    = $clog2(X_LIM);
  localparam int unsigned YW    = $clog2(Y_LIM);
  localparam int unsigned ZW    = $clog2(Z_LIM);
  localparam int unsigned AW    = XW + YW + ZW;
  localparam int unsigned DEPTH = 1 << AW;
  // The size registers are six bits, so a bound above 63 never clips them.
  localparam int unsigned W_CAP = (MAX_WIDTH  > 63) ? 63 : MAX_WIDTH;
  localparam int unsigned H_CAP = (MAX_HEIGHT > 63) ? 63 : MAX_HEIGHT;
  localparam int unsigned D_CAP = (MAX_DEPTH  > 63) ? 63 : MAX_DEPTH;

  typedef logic [AW-1:0] addr_t;

  typedef enum logic [6:0] {
    ST_WIPE = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_CTR  = 7'b0000100,
    ST_NRD  = 7'b0001000,
    ST_STAT = 7'b0010000,
    ST_SHOW = 7'b0100000,
    ST_UPD  = 7'b1000000
  } state_t;

  typedef struct packed {
    vfmu_pkg::kind_t  kind;
    vfmu_pkg::coord_t x;
    vfmu_pkg::coord_t y;
    vfmu_pkg::coord_t z;
    vfmu_pkg::face_t  face;
    vfmu_pkg::mask_t  mask;
    logic             last;
  } out_item_t;

  function automatic vfmu_pkg::dim_t clamp_dim(vfmu_pkg::dim_t v, vfmu_pkg::dim_t cap);
    vfmu_pkg::dim_t r;
    if (v == '0) begin
      r = 6'd1;
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Cells are laid out as {y, z, x}; only the bits the grid bounds need are kept.
  function automatic addr_t mk_addr(vfmu_pkg::coord_t x, vfmu_pkg::coord_t y,
                                    vfmu_pkg::coord_t z);
    return {y[YW-1:0], z[ZW-1:0], x[XW-1:0]};
  endfunction

  state_t                state_r, state_nxt;
  addr_t                 wipe_r, wipe_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  vfmu_pkg::dim_t        grid_w_r, grid_d_r, grid_h_r;
  vfmu_pkg::coord_t      x_r, y_r, z_r;
  logic [7:0]            mat_r;
  logic                  clr_r;
  vfmu_pkg::cell_t       nb_r [vfmu_pkg::NUM_FACES];
  out_item_t             out_r;
  logic                  out_valid_r;

  logic                  ram_we;
  addr_t                 ram_addr;
  vfmu_pkg::cell_t       ram_wdata;
  vfmu_pkg::cell_t       ram_rdata;

  vfmu_pkg::dim_t        eff_w, eff_d, eff_h;
  logic                  in_grid;
  vfmu_pkg::coord_t      nx [vfmu_pkg::NUM_FACES];
  vfmu_pkg::coord_t      ny [vfmu_pkg::NUM_FACES];
  vfmu_pkg::coord_t      nz [vfmu_pkg::NUM_FACES];
  addr_t                 nb_addr [vfmu_pkg::NUM_FACES];
  vfmu_pkg::mask_t       ing, rch, occ_n, own_m, elig, new_mask;
  addr_t                 ctr_addr;
  vfmu_pkg::face_t       cur_f, dir_f;
  logic                  slot_free;
  logic                  emit;
  out_item_t             ev;
  logic                  cur_occ, in_clr, same;

  vfmu_ram #(
    .WIDTH ($bits(vfmu_pkg::cell_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign eff_w    = clamp_dim(grid_w_r, 6'(W_CAP));
  assign eff_d    = clamp_dim(grid_d_r, 6'(D_CAP));
  assign eff_h    = clamp_dim(grid_h_r, 6'(H_CAP));
  assign in_grid  = ({1'b0, x_r} < eff_w) && ({1'b0, y_r} < eff_h) && ({1'b0, z_r} < eff_d);
  assign ctr_addr = mk_addr(x_r, y_r, z_r);

  // Neighbour coordinates for every face direction and whether they lie in the grid.
  always_comb begin
    for (int d = 0; d < vfmu_pkg::NUM_FACES; d++) begin
      nx[d] = x_r;
      ny[d] = y_r;
      nz[d] = z_r;
    end
    nz[vfmu_pkg::FACE_PZ] = z_r + 5'd1;
    nx[vfmu_pkg::FACE_PX] = x_r + 5'd1;
    nz[vfmu_pkg::FACE_NZ] = z_r - 5'd1;
    nx[vfmu_pkg::FACE_NX] = x_r - 5'd1;
    ny[vfmu_pkg::FACE_PY] = y_r + 5'd1;
    ny[vfmu_pkg::FACE_NY] = y_r - 5'd1;
    for (int d = 0; d < vfmu_pkg::NUM_FACES; d++) begin
      nb_addr[d] = mk_addr(nx[d], ny[d], nz[d]);
    end
    ing[vfmu_pkg::FACE_PZ] = ({1'b0, z_r} + 6'd1) < eff_d;
    ing[vfmu_pkg::FACE_PX] = ({1'b0, x_r} + 6'd1) < eff_w;
    ing[vfmu_pkg::FACE_NZ] = z_r != '0;
    ing[vfmu_pkg::FACE_NX] = x_r != '0;
    ing[vfmu_pkg::FACE_PY] = ({1'b0, y_r} + 6'd1) < eff_h;
    ing[vfmu_pkg::FACE_NY] = y_r != '0;
    // With a bound above 32 the cell past coordinate 31 lies in the grid but can
    // never be written, so it always counts as empty.
    rch                    = vfmu_pkg::ALL_FACES;
    rch[vfmu_pkg::FACE_PZ] = z_r != '1;
    rch[vfmu_pkg::FACE_PX] = x_r != '1;
    rch[vfmu_pkg::FACE_PY] = y_r != '1;
  end

  // occ_n is indexed by direction, elig by the neighbour's face that points back.
  always_comb begin
    for (int d = 0; d < vfmu_pkg::NUM_FACES; d++) begin
      occ_n[d] = ing[d] & rch[d] & ~nb_r[d].mat[7];
    end
    for (int f = 0; f < vfmu_pkg::NUM_FACES; f++) begin
      elig[f] = occ_n[vfmu_pkg::across(3'(f))];
    end
  end

  // Outside the grid counts as occupied.
  assign own_m     = ~ing | occ_n;
  assign cur_f     = cnt_r;
  assign dir_f     = vfmu_pkg::across(cur_f);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign cur_occ   = !ram_rdata.mat[7];
  assign in_clr    = mat_r[7];
  assign same      = (in_clr && !cur_occ) || (!in_clr && cur_occ && ram_rdata.mat == mat_r);

  always_comb begin
    if (cnt_r < 3'(vfmu_pkg::NUM_FACES)) begin
      new_mask = clr_r ? (nb_r[dir_f].mask & ~(6'b1 << cur_f))
                       : (nb_r[dir_f].mask | (6'b1 << cur_f));
    end else begin
      new_mask = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wipe_nxt  = wipe_r;
    ram_we    = 1'b0;
    ram_addr  = ctr_addr;
    ram_wdata = vfmu_pkg::EMPTY_CELL;
    emit      = 1'b0;
    ev        = '{kind: vfmu_pkg::EV_UNCHANGED, x: x_r, y: y_r, z: z_r,
                  face: vfmu_pkg::FACE_PZ, mask: '0, last: 1'b1};
    case (state_r)
      ST_WIPE: begin
        ram_we   = 1'b1;
        ram_addr = wipe_r;
        wipe_nxt = wipe_r + addr_t'(1);
        if (wipe_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_addr = mk_addr(in_chan.x_pos, in_chan.y_pos, in_chan.z_pos);
        if (in_chan.valid) begin
          state_nxt = ST_CTR;
        end
      end
      ST_CTR: begin
        // The centre cell read is repeated each cycle here, so the data holds on a stall.
        if (!in_grid) begin
          ev.kind = vfmu_pkg::EV_REJECTED;
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (same) begin
          ev.kind = vfmu_pkg::EV_UNCHANGED;
          ev.mask = cur_occ ? ram_rdata.mask : '0;
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (!in_clr && cur_occ) begin
          ev.kind   = vfmu_pkg::EV_CHANGED;
          ev.mask   = ram_rdata.mask;
          ram_wdata = '{mat: mat_r, mask: ram_rdata.mask};
          if (slot_free) begin
            emit      = 1'b1;
            ram_we    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_NRD;
        end
      end
      ST_NRD: begin
        // Reads go out on counts 0 to 5; each lands one count later.
        if (cnt_r < 3'(vfmu_pkg::NUM_FACES)) begin
          ram_addr = nb_addr[cnt_r];
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(vfmu_pkg::NUM_FACES)) begin
          cnt_nxt   = '0;
          state_nxt = ST_STAT;
        end
      end
      ST_STAT: begin
        if (clr_r) begin
          ev.kind = vfmu_pkg::EV_CLEARED;
          ev.last = elig == '0;
        end else begin
          ev.kind   = vfmu_pkg::EV_INSERTED;
          ev.mask   = own_m;
          ev.last   = (own_m == vfmu_pkg::ALL_FACES) && (elig == '0);
          ram_wdata = '{mat: mat_r, mask: own_m};
        end
        if (slot_free) begin
          emit      = 1'b1;
          ram_we    = 1'b1;
          cnt_nxt   = '0;
          state_nxt = clr_r ? ST_UPD : ST_SHOW;
        end
      end
      ST_SHOW: begin
        ev.kind = vfmu_pkg::EV_SHOWN;
        ev.face = cur_f;
        ev.mask = own_m;
        ev.last = ((~own_m >> (cnt_r + 3'd1)) == '0) && (elig == '0);
        if (own_m[cur_f] || slot_free) begin
          emit    = !own_m[cur_f];
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'(vfmu_pkg::NUM_FACES - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        ev.kind   = clr_r ? vfmu_pkg::EV_SHOWN : vfmu_pkg::EV_HIDDEN;
        ev.x      = nx[dir_f];
        ev.y      = ny[dir_f];
        ev.z      = nz[dir_f];
        ev.face   = cur_f;
        ev.mask   = new_mask;
        ev.last   = (elig >> (cnt_r + 3'd1)) == '0;
        ram_addr  = nb_addr[dir_f];
        ram_wdata = '{mat: nb_r[dir_f].mat, mask: new_mask};
        if (!elig[cur_f] || slot_free) begin
          emit    = elig[cur_f];
          ram_we  = elig[cur_f];
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'(vfmu_pkg::NUM_FACES - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      wipe_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      grid_w_r    <= vfmu_pkg::DIM_RESET;
      grid_d_r    <= vfmu_pkg::DIM_RESET;
      grid_h_r    <= vfmu_pkg::DIM_RESET;
    end else begin
      state_r <= state_nxt;
      wipe_r  <= wipe_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          vfmu_pkg::REG_GRID_WIDTH:  grid_w_r <= cfg_chan.data;
          vfmu_pkg::REG_GRID_DEPTH:  grid_d_r <= cfg_chan.data;
          vfmu_pkg::REG_GRID_HEIGHT: grid_h_r <= cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_chan.valid) begin
      x_r   <= in_chan.x_pos;
      y_r   <= in_chan.y_pos;
      z_r   <= in_chan.z_pos;
      mat_r <= in_chan.material;
    end
    if (state_r == ST_CTR) begin
      clr_r <= in_clr;
    end
    if (state_r == ST_NRD && cnt_r != '0) begin
      nb_r[cnt_r - 3'd1] <= ram_rdata;
    end
    if (emit) begin
      out_r <= ev;
    end
  end

  assign in_chan.ready       = state_r == ST_IDLE;
  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.event_kind = out_r.kind;
  assign out_chan.cell_x     = out_r.x;
  assign out_chan.cell_y     = out_r.y;
  assign out_chan.cell_z     = out_r.z;
  assign out_chan.face       = out_r.face;
  assign out_chan.cell_mask  = out_r.mask;
  assign out_chan.last       = out_r.last;

endmodule

@@ rtl/core/vfmu_checker.sv @@
module vfmu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input vfmu_pkg::kind_t    out_kind,
  input vfmu_pkg::coord_t   out_x,
  input vfmu_pkg::coord_t   out_y,
  input vfmu_pkg::coord_t   out_z,
  input vfmu_pkg::face_t    out_face,
  input vfmu_pkg::mask_t    out_mask,
  input logic               out_last
);

  // Updates accepted whose final result has not yet been taken.
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready && out_last);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_x) &&
      $stable(out_y) && $stable(out_z) && $stable(out_face) && $stable(out_mask) &&
      $stable(out_last)))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd0) |-> !out_valid)
    else $error("result without an accepted update");

  a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == vfmu_pkg::EV_UNCHANGED || out_kind == vfmu_pkg::EV_CHANGED ||
      out_kind == vfmu_pkg::EV_REJECTED)) |-> out_last)
    else $error("status-only update not marked last");

  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == vfmu_pkg::EV_REJECTED || out_kind == vfmu_pkg::EV_CLEARED))
      |-> (out_mask == '0 && out_face == vfmu_pkg::FACE_PZ))
    else $error("removed or rejected cell reports a mask");

endmodule

bind voxel_face_mask_updater vfmu_checker u_vfmu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.event_kind),
  .out_x     (out_chan.cell_x),
  .out_y     (out_chan.cell_y),
  .out_z     (out_chan.cell_z),
  .out_face  (out_chan.face),
  .out_mask  (out_chan.cell_mask),
  .out_last  (out_chan.last)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

// Testbench for the voxel face mask updater. Voxel updates are queued by the
// stimulus process and presented by a clocked driver; every accepted update is
// run through a mirror of the voxel grid, which appends the expected status
// and face transactions to a queue. A clocked monitor takes each result
// transaction in order and compares it field by field with the oldest
// expectation. The grid size registers are rewritten between phases, only
// once the block has gone quiet.
module tb;

  localparam int GRID_MAX = 32;
  localparam int NUM_CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int FACE_COUNT = int'(vfmu_pkg::NUM_FACES);
  // This margin lets any tail of the slowest update settle.
  localparam int DRAIN_CYCLES = 40;
  // The clearing sweep after reset passes without a transaction.
  localparam int STALL_LIMIT = 100000;
  localparam int MAX_REPORTS = 40;
  localparam logic [7:0] EMPTY_MATERIAL = 8'hFF;

  typedef struct packed {
    vfmu_pkg::coord_t x;
    vfmu_pkg::coord_t y;
    vfmu_pkg::coord_t z;
    logic [7:0]       mat;
  } voxel_write_t;

  typedef struct packed {
    vfmu_pkg::kind_t  kind;
    vfmu_pkg::coord_t x;
    vfmu_pkg::coord_t y;
    vfmu_pkg::coord_t z;
    vfmu_pkg::face_t  face;
    vfmu_pkg::mask_t  mask;
    logic             last;
  } face_event_t;

  typedef struct packed {
    vfmu_pkg::reg_idx_t index;
    vfmu_pkg::dim_t     data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vfmu_in_if  in_if ();
  vfmu_out_if out_if ();
  vfmu_cfg_if cfg_if ();

  voxel_face_mask_updater i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  voxel_write_t write_queue[$];
  face_event_t  expected_events[$];
  reg_write_t   reg_writes[$];

  // Mirror of the voxel store and of the grid size registers.
  logic [7:0]      material_mirror [NUM_CELLS];
  vfmu_pkg::mask_t mask_mirror [NUM_CELLS];
  vfmu_pkg::dim_t  width_reg;
  vfmu_pkg::dim_t  depth_reg;
  vfmu_pkg::dim_t  height_reg;

  int mismatches = 0;
  int quiet_cycles = 0;
  // When set, neither side idles: this gives one long stretch at full rate.
  bit steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A register value of 0 behaves as 1 and anything above the bound as the bound.
  function automatic int used_size(vfmu_pkg::dim_t v);
    if (v == '0) return 1;
    if (int'(v) > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic int cell_at(int x, int y, int z);
    return (y * GRID_MAX + z) * GRID_MAX + x;
  endfunction

  // The face of the neighbour that touches face f of this cell.
  function automatic int opposite(int f);
    case (vfmu_pkg::face_t'(f))
      vfmu_pkg::FACE_PZ: return vfmu_pkg::FACE_NZ;
      vfmu_pkg::FACE_PX: return vfmu_pkg::FACE_NX;
      vfmu_pkg::FACE_NZ: return vfmu_pkg::FACE_PZ;
      vfmu_pkg::FACE_NX: return vfmu_pkg::FACE_PX;
      vfmu_pkg::FACE_PY: return vfmu_pkg::FACE_NY;
      default: return vfmu_pkg::FACE_PY;
    endcase
  endfunction

  // Steps across face f and tells whether the neighbour lies inside the grid
  // as currently sized.
  function automatic bit neighbour_of(int x, int y, int z, int f,
                                      output int nx, output int ny, output int nz);
    nx = x;
    ny = y;
    nz = z;
    case (vfmu_pkg::face_t'(f))
      vfmu_pkg::FACE_PZ: nz = z + 1;
      vfmu_pkg::FACE_PX: nx = x + 1;
      vfmu_pkg::FACE_NZ: nz = z - 1;
      vfmu_pkg::FACE_NX: nx = x - 1;
      vfmu_pkg::FACE_PY: ny = y + 1;
      default: ny = y - 1;
    endcase
    return nx >= 0 && nx < used_size(width_reg) && ny >= 0 && ny < used_size(height_reg)
           && nz >= 0 && nz < used_size(depth_reg);
  endfunction

  function automatic face_event_t make_event(vfmu_pkg::kind_t k, int x, int y, int z, int f,
                                             vfmu_pkg::mask_t m);
    face_event_t e;
    e.kind = k;
    e.x    = vfmu_pkg::coord_t'(x);
    e.y    = vfmu_pkg::coord_t'(y);
    e.z    = vfmu_pkg::coord_t'(z);
    e.face = vfmu_pkg::face_t'(f);
    e.mask = m;
    e.last = 1'b0;
    return e;
  endfunction

  // Applies one voxel update to the mirror and queues the transactions that
  // the block must send back for it, the final one flagged as last.
  function automatic void predict_update(voxel_write_t w);
    face_event_t evs[$];
    int x, y, z, ci, ni, nx, ny, nz, f;
    bit removing, occupied;
    vfmu_pkg::mask_t m;
    x = w.x;
    y = w.y;
    z = w.z;
    removing = w.mat[7];
    if (x >= used_size(width_reg) || y >= used_size(height_reg) ||
        z >= used_size(depth_reg)) begin
      evs.insert(evs.size(), make_event(vfmu_pkg::EV_REJECTED, x, y, z, 0, '0));
    end else begin
      ci = cell_at(x, y, z);
      occupied = !material_mirror[ci][7];
      if ((removing && !occupied) ||
          (!removing && occupied && material_mirror[ci] == w.mat)) begin
        evs.insert(evs.size(), make_event(vfmu_pkg::EV_UNCHANGED, x, y, z, 0,
                                          occupied ? mask_mirror[ci] : vfmu_pkg::mask_t'(0)));
      end else if (removing) begin
        // The cell's own faces disappear with it; only neighbours report.
        material_mirror[ci] = EMPTY_MATERIAL;
        mask_mirror[ci] = '0;
        evs.insert(evs.size(), make_event(vfmu_pkg::EV_CLEARED, x, y, z, 0, '0));
        for (f = 0; f < FACE_COUNT; f++) begin
          if (neighbour_of(x, y, z, opposite(f), nx, ny, nz)) begin
            ni = cell_at(nx, ny, nz);
            if (!material_mirror[ni][7]) begin
              mask_mirror[ni] = mask_mirror[ni] & ~(vfmu_pkg::mask_t'(1) << f);
              evs.insert(evs.size(),
                         make_event(vfmu_pkg::EV_SHOWN, nx, ny, nz, f, mask_mirror[ni]));
            end
          end
        end
      end else if (occupied) begin
        material_mirror[ci] = w.mat;
        evs.insert(evs.size(), make_event(vfmu_pkg::EV_CHANGED, x, y, z, 0, mask_mirror[ci]));
      end else begin
        // Cells outside the grid count as occupied neighbours.
        material_mirror[ci] = w.mat;
        m = '0;
        for (f = 0; f < FACE_COUNT; f++) begin
          if (!neighbour_of(x, y, z, f, nx, ny, nz) ||
              !material_mirror[cell_at(nx, ny, nz)][7])
            m[f] = 1'b1;
        end
        mask_mirror[ci] = m;
        evs.insert(evs.size(), make_event(vfmu_pkg::EV_INSERTED, x, y, z, 0, m));
        for (f = 0; f < FACE_COUNT; f++) begin
          if (!m[f]) evs.insert(evs.size(), make_event(vfmu_pkg::EV_SHOWN, x, y, z, f, m));
        end
        for (f = 0; f < FACE_COUNT; f++) begin
          if (neighbour_of(x, y, z, opposite(f), nx, ny, nz)) begin
            ni = cell_at(nx, ny, nz);
            if (!material_mirror[ni][7]) begin
              mask_mirror[ni] = mask_mirror[ni] | (vfmu_pkg::mask_t'(1) << f);
              evs.insert(evs.size(),
                         make_event(vfmu_pkg::EV_HIDDEN, nx, ny, nz, f, mask_mirror[ni]));
            end
          end
        end
      end
    end
    evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) expected_events.insert(expected_events.size(), evs[i]);
  endfunction

  function automatic string describe(face_event_t e);
    return $sformatf("kind %0d cell (%0d,%0d,%0d) face %0d mask %02h last %0d",
                     e.kind, e.x, e.y, e.z, e.face, e.mask, e.last);
  endfunction

  function automatic string differing_fields(face_event_t got, face_event_t want);
    string s;
    s = "";
    if (got.kind !== want.kind) s = {s, " event_kind"};
    if (got.x !== want.x) s = {s, " cell_x"};
    if (got.y !== want.y) s = {s, " cell_y"};
    if (got.z !== want.z) s = {s, " cell_z"};
    if (got.face !== want.face) s = {s, " face"};
    if (got.mask !== want.mask) s = {s, " cell_mask"};
    if (got.last !== want.last) s = {s, " last"};
    return s;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string what);
    if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Update driver. An accepted transaction goes straight to the mirror; a new
  // item is only presented once the previous one has been taken.
  always @(posedge clk) begin : update_driver
    voxel_write_t taken;
    voxel_write_t next_item;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken.x   = in_if.x_pos;
        taken.y   = in_if.y_pos;
        taken.z   = in_if.z_pos;
        taken.mat = in_if.material;
        predict_update(taken);
      end
      if (!in_if.valid || in_if.ready) begin
        if (write_queue.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
          next_item = write_queue.pop_front();
          in_if.valid    <= 1'b1;
          in_if.x_pos    <= next_item.x;
          in_if.y_pos    <= next_item.y;
          in_if.z_pos    <= next_item.z;
          in_if.material <= next_item.mat;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver. The mirror takes each value on its transaction.
  always @(posedge clk) begin : reg_driver
    reg_write_t next_write;
    if (!rst_n) begin
      cfg_if.valid <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          vfmu_pkg::REG_GRID_WIDTH:  width_reg = cfg_if.data;
          vfmu_pkg::REG_GRID_DEPTH:  depth_reg = cfg_if.data;
          vfmu_pkg::REG_GRID_HEIGHT: height_reg = cfg_if.data;
          default: ;
        endcase
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (reg_writes.size() != 0) begin
          next_write = reg_writes.pop_front();
          cfg_if.valid <= 1'b1;
          cfg_if.index <= next_write.index;
          cfg_if.data  <= next_write.data;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : result_monitor
    face_event_t got;
    face_event_t want;
    string diffs;
    if (!rst_n) begin
      out_if.ready <= 1'b1;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.event_kind;
        got.x    = out_if.cell_x;
        got.y    = out_if.cell_y;
        got.z    = out_if.cell_z;
        got.face = out_if.face;
        got.mask = out_if.cell_mask;
        got.last = out_if.last;
        if (expected_events.size() == 0) begin
          report_mismatch({"result with nothing expected: ", describe(got)});
        end else begin
          want = expected_events.pop_front();
          diffs = differing_fields(got, want);
          if (diffs != "")
            report_mismatch($sformatf("%s differ: got %s, expected %s", diffs,
                                      describe(got), describe(want)));
        end
      end
      out_if.ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // Ends the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin : stall_watchdog
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[voxel_face_mask_updater] ERROR");
        $finish;
      end
    end
  end

  task automatic push_update(int x, int y, int z, int mat);
    voxel_write_t w;
    w.x   = vfmu_pkg::coord_t'(x);
    w.y   = vfmu_pkg::coord_t'(y);
    w.z   = vfmu_pkg::coord_t'(z);
    w.mat = 8'(mat);
    write_queue.insert(write_queue.size(), w);
  endtask

  task automatic queue_reg_write(vfmu_pkg::reg_idx_t idx, int value);
    reg_write_t r;
    r.index = idx;
    r.data  = vfmu_pkg::dim_t'(value);
    reg_writes.insert(reg_writes.size(), r);
  endtask

  // Mostly inside a four-cell window so that neighbours interact, sometimes
  // anywhere in the coordinate range.
  function automatic int pick_coord(int org);
    if ($urandom_range(99) < 12) return $urandom_range(31, 0);
    return org + $urandom_range(3, 0);
  endfunction

  // Removals, a small palette that makes repeats likely, and any other value.
  function automatic int pick_material();
    int r;
    r = $urandom_range(99);
    if (r < 35) return $urandom_range(255, 128);
    if (r < 60) return $urandom_range(2, 0);
    return $urandom_range(127, 0);
  endfunction

  task automatic queue_random(int count, int ox, int oy, int oz);
    int k;
    for (k = 0; k < count; k++)
      push_update(pick_coord(ox), pick_coord(oy), pick_coord(oz), pick_material());
  endtask

  // Waits until every update has been taken and answered, then lets the block
  // settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (write_queue.size() != 0 || in_if.valid || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid(int w, int d, int h);
    queue_reg_write(vfmu_pkg::REG_GRID_WIDTH, w);
    queue_reg_write(vfmu_pkg::REG_GRID_DEPTH, d);
    queue_reg_write(vfmu_pkg::REG_GRID_HEIGHT, h);
    do @(posedge clk);
    while (reg_writes.size() != 0 || cfg_if.valid);
  endtask

  initial begin : stimulus
    int i;
    in_if.valid    = 1'b0;
    in_if.x_pos    = '0;
    in_if.y_pos    = '0;
    in_if.z_pos    = '0;
    in_if.material = '0;
    out_if.ready   = 1'b1;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = vfmu_pkg::REG_GRID_WIDTH;
    cfg_if.data    = '0;
    width_reg  = vfmu_pkg::DIM_RESET;
    depth_reg  = vfmu_pkg::DIM_RESET;
    height_reg = vfmu_pkg::DIM_RESET;
    for (i = 0; i < NUM_CELLS; i++) begin
      material_mirror[i] = EMPTY_MATERIAL;
      mask_mirror[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Full grid from reset. A corner voxel sees three outside faces as
    // occupied; then same material, a material change, a neighbour hiding a
    // face, a removal showing it again and a removal of an empty cell.
    push_update(0, 0, 0, 5);
    push_update(0, 0, 0, 5);
    push_update(0, 0, 0, 9);
    push_update(1, 0, 0, 9);
    push_update(0, 0, 0, -1);
    push_update(0, 0, 0, -128);
    push_update(31, 31, 31, 127);
    push_update(31, 31, 31, 127);
    push_update(31, 31, 31, -128);
    // Surround a cell on all six sides, fill it (every face hidden, seven
    // results) and remove it again (every neighbour face shown).
    push_update(10, 10, 11, 1);
    push_update(11, 10, 10, 2);
    push_update(10, 10, 9, 3);
    push_update(9, 10, 10, 4);
    push_update(10, 11, 10, 5);
    push_update(10, 9, 10, 6);
    push_update(10, 10, 10, 0);
    push_update(10, 10, 10, -5);
    push_update(10, 10, 10, 127);
    push_update(5, 31, 0, -1);
    queue_random(40, 0, 0, 0);
    queue_random(30, 28, 28, 28);
    wait_idle();

    // A zero width acts as one and an oversized height as the full bound.
    write_grid(0, 1, 63);
    push_update(0, 0, 0, 3);
    push_update(1, 0, 0, 4);
    push_update(0, 0, 1, 4);
    queue_random(35, 0, 0, 0);
    wait_idle();

    // A single-cell grid: an inserted voxel has every face against the outside.
    write_grid(1, 1, 1);
    push_update(0, 0, 0, -1);
    push_update(0, 0, 0, 7);
    queue_random(15, 0, 0, 0);
    wait_idle();

    // A small cube at full rate on both sides.
    write_grid(4, 4, 4);
    steady = 1'b1;
    queue_random(50, 0, 0, 0);
    wait_idle();
    steady = 1'b0;

    // A flat slab: oversized width, shallow depth and height.
    write_grid(63, 2, 5);
    queue_random(40, 28, 0, 0);
    wait_idle();

    // Back to the full grid: cells outside the smaller sizes kept their state.
    write_grid(32, 32, 32);
    push_update(10, 10, 11, 1);
    push_update(11, 10, 10, -1);
    push_update(31, 0, 31, 0);
    queue_random(45, 8, 8, 8);
    wait_idle();

    if (mismatches == 0) begin
      $display("[voxel_face_mask_updater] OK");
    end else begin
      $display("[voxel_face_mask_updater] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/vfmu_pkg.sv
rtl/core/vfmu_if.sv
rtl/core/vfmu_ram.sv
rtl/core/voxel_face_mask_updater.sv
rtl/core/vfmu_checker.sv
tb/sv/tb.sv
